[rtl/core/hsl_to_rgb_pixel_converter_unit_macros.svh]
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define H2R_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define H2R_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Pixel types, hue sector codes and fixed-point constants of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

	// Input pixel: hue in tenths of a degree, S and L in tenths of a percent.
	typedef struct packed {
		logic [11:0] hue;
		logic [9:0]  saturation;
		logic [9:0]  lightness;
		logic [11:0] alpha_in;
	} hsla_t;

	// Output pixel: unsigned Q0.12 channels.
	typedef struct packed {
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
		logic [11:0] alpha_out;
	} rgba_t;

	// Sixty-degree hue sectors.
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// Side information that rides along the arithmetic pipeline.
	typedef struct packed {
		sector_t     sector;
		logic [11:0] alpha;
	} side_t;

	// Hue and percentage scales.
	localparam logic [11:0] HUE_TURN   = 12'd3600;
	localparam logic [11:0] HUE_SECTOR = 12'd600;
	localparam logic [11:0] HUE_PAIR   = 12'd1200;
	localparam logic [9:0]  PCT_FULL   = 10'd1000;

	// Channel values are formed over a common denominator of 1.2e9.
	localparam logic [20:0] L_SCALE = 21'd1200000;
	localparam logic [9:0]  C_SCALE = 10'd600;

	// Quantizer: q = floor((8v + Y_BIAS) / DIV_D), same as round(v * 4096 / 1.2e9).
	localparam logic [33:0] Y_BIAS = 34'd1171875;
	localparam logic [21:0] DIV_D  = 22'd2343750;
	// floor(2^44 / DIV_D); estimate is taken from the top 22 bits of y.
	localparam logic [22:0] RECIP  = 23'd7505999;
	localparam logic [11:0] Q12_MAX = 12'd4095;

endpackage

`default_nettype wire

[rtl/core/h2r_front.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter front end
// Four-stage chroma pipeline: wraps and clamps the inputs, forms chroma, the
// secondary term and the offset, and gives the three biased channel numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire h2r_pkg::hsla_t    hsla,
	output logic                   out_valid,
	output logic [33:0]            y_c,
	output logic [33:0]            y_x,
	output logic [33:0]            y_m,
	output h2r_pkg::side_t         side
);

	// Stage 1 signals.
	logic [11:0] hue_wrap;
	logic [9:0]  sat_clamp;
	logic [9:0]  lig_clamp;
	logic [10:0] lig_dbl;
	logic [10:0] dev;
	logic [9:0]  cw;
	logic        v_s1;
	logic [11:0] hue_s1;
	logic [9:0]  sat_s1;
	logic [9:0]  lig_s1;
	logic [9:0]  cw_s1;
	logic [11:0] alpha_s1;

	// Stage 2 signals.
	h2r_pkg::sector_t sector;
	logic [11:0] h2;
	logic [11:0] xw;
	logic        v_s2;
	logic [19:0] cnum_s2;
	logic [9:0]  xw_s2;
	logic [9:0]  lig_s2;
	h2r_pkg::side_t side_s2;

	// Stage 3 signals.
	logic        v_s3;
	logic [29:0] xprod_s3;
	logic [30:0] lterm_s3;
	logic [29:0] cterm_s3;
	h2r_pkg::side_t side_s3;

	// Stage 4 signals.
	logic [30:0] mv;
	logic [30:0] vc;
	logic [30:0] vx;
	logic        v_s4;
	logic [33:0] yc_s4;
	logic [33:0] yx_s4;
	logic [33:0] ym_s4;
	h2r_pkg::side_t side_s4;

	// Valid bits travel with the pixel through all four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: wrap the hue into one turn, clamp S and L, and find 1 - |2L - 1|.
	always_comb begin
		hue_wrap  = (hsla.hue >= h2r_pkg::HUE_TURN) ? hsla.hue - h2r_pkg::HUE_TURN
			: hsla.hue;
		sat_clamp = (hsla.saturation > h2r_pkg::PCT_FULL) ? h2r_pkg::PCT_FULL
			: hsla.saturation;
		lig_clamp = (hsla.lightness > h2r_pkg::PCT_FULL) ? h2r_pkg::PCT_FULL
			: hsla.lightness;
		lig_dbl   = {lig_clamp, 1'b0};
		dev       = (lig_dbl >= 11'(h2r_pkg::PCT_FULL)) ? lig_dbl - 11'(h2r_pkg::PCT_FULL)
			: 11'(h2r_pkg::PCT_FULL) - lig_dbl;
		cw        = h2r_pkg::PCT_FULL - dev[9:0];
	end

	always_ff @(posedge clk) begin
		hue_s1   <= hue_wrap;
		sat_s1   <= sat_clamp;
		lig_s1   <= lig_clamp;
		cw_s1    <= cw;
		alpha_s1 <= hsla.alpha_in;
	end

	// Stage 2: chroma numerator, hue sector and the triangle weight of X.
	always_comb begin
		if (hue_s1 < h2r_pkg::HUE_SECTOR) begin
			sector = h2r_pkg::SEC_RED_YEL;
		end else if (hue_s1 < 12'(2 * h2r_pkg::HUE_SECTOR)) begin
			sector = h2r_pkg::SEC_YEL_GRN;
		end else if (hue_s1 < 12'(3 * h2r_pkg::HUE_SECTOR)) begin
			sector = h2r_pkg::SEC_GRN_CYN;
		end else if (hue_s1 < 12'(4 * h2r_pkg::HUE_SECTOR)) begin
			sector = h2r_pkg::SEC_CYN_BLU;
		end else if (hue_s1 < 12'(5 * h2r_pkg::HUE_SECTOR)) begin
			sector = h2r_pkg::SEC_BLU_MAG;
		end else begin
			sector = h2r_pkg::SEC_MAG_RED;
		end
		if (hue_s1 >= 12'(2 * h2r_pkg::HUE_PAIR)) begin
			h2 = hue_s1 - 12'(2 * h2r_pkg::HUE_PAIR);
		end else if (hue_s1 >= h2r_pkg::HUE_PAIR) begin
			h2 = hue_s1 - h2r_pkg::HUE_PAIR;
		end else begin
			h2 = hue_s1;
		end
		xw = (h2 >= h2r_pkg::HUE_SECTOR) ? h2r_pkg::HUE_PAIR - h2 : h2;
	end

	always_ff @(posedge clk) begin
		cnum_s2       <= cw_s1 * sat_s1;
		xw_s2         <= xw[9:0];
		lig_s2        <= lig_s1;
		side_s2.sector <= sector;
		side_s2.alpha  <= alpha_s1;
	end

	// Stage 3: the three independent products of the channel terms.
	always_ff @(posedge clk) begin
		xprod_s3 <= cnum_s2 * xw_s2;
		lterm_s3 <= lig_s2 * h2r_pkg::L_SCALE;
		cterm_s3 <= cnum_s2 * h2r_pkg::C_SCALE;
		side_s3  <= side_s2;
	end

	// Stage 4: add the offset to C and X, then scale and bias for the quantizer.
	always_comb begin
		mv = lterm_s3 - {1'b0, cterm_s3};
		vc = {cterm_s3, 1'b0} + mv;
		vx = {xprod_s3, 1'b0} + mv;
	end

	always_ff @(posedge clk) begin
		yc_s4   <= {vc, 3'b000} + h2r_pkg::Y_BIAS;
		yx_s4   <= {vx, 3'b000} + h2r_pkg::Y_BIAS;
		ym_s4   <= {mv, 3'b000} + h2r_pkg::Y_BIAS;
		side_s4 <= side_s3;
	end

	assign out_valid = v_s4;
	assign y_c       = yc_s4;
	assign y_x       = yx_s4;
	assign y_m       = ym_s4;
	assign side      = side_s4;

endmodule

`default_nettype wire

[rtl/core/h2r_q12_round.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter channel quantizer
// Three-stage divide by a constant: reciprocal estimate, back multiply, and one
// correction step, then saturation to the 12-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_q12_round (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [33:0] y,
	output logic             out_valid,
	output logic [11:0]      q
);

	logic [44:0] est_prod;
	logic [34:0] back_prod;
	logic [33:0] rem;
	logic        bump;
	logic [12:0] q_full;

	logic        v_s5;
	logic        v_s6;
	logic        v_s7;
	logic [12:0] est_s5;
	logic [33:0] y_s5;
	logic [12:0] est_s6;
	logic [33:0] back_s6;
	logic [33:0] y_s6;
	logic [11:0] q_s7;

	// Valid bits for the three quantizer stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 5: quotient estimate from the top bits; it is exact or one short.
	assign est_prod = y[33:12] * h2r_pkg::RECIP;

	always_ff @(posedge clk) begin
		est_s5 <= est_prod[44:32];
		y_s5   <= y;
	end

	// Stage 6: multiply the estimate back by the divisor.
	assign back_prod = est_s5 * h2r_pkg::DIV_D;

	always_ff @(posedge clk) begin
		back_s6 <= back_prod[33:0];
		est_s6  <= est_s5;
		y_s6    <= y_s5;
	end

	// Stage 7: correct the estimate by the remainder and saturate at full scale.
	always_comb begin
		rem    = y_s6 - back_s6;
		bump   = (rem >= 34'(h2r_pkg::DIV_D));
		q_full = est_s6 + 13'(bump);
	end

	always_ff @(posedge clk) begin
		q_s7 <= q_full[12] ? h2r_pkg::Q12_MAX : q_full[11:0];
	end

	assign out_valid = v_s7;
	assign q         = q_s7;

endmodule

`default_nettype wire

[rtl/core/hsl_to_rgb_pixel_converter_unit.sv]
// ----------------------------------------------------------------------------
// HSL to RGB pixel converter
// Converts one HSLA pixel per clock into an RGBA pixel in unsigned Q0.12.
// ----------------------------------------------------------------------------
// The unit accepts a pixel on every clock at which start is high; busy is
// always low, so pixels may be issued back to back without gaps. Each result
// appears on rgba for exactly one cycle with done high, in issue order. The
// path from the transfer that carried its input to the result runs through the
// eight register stages: four in the chroma front end, three in the per-channel
// quantizer that divides by a constant through a reciprocal multiply, and the
// output register that routes the channels by hue sector. The receiver cannot
// stall the unit and must take each result in the cycle it is presented.
`default_nettype none

`include "hsl_to_rgb_pixel_converter_unit_macros.svh"

module hsl_to_rgb_pixel_converter_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire h2r_pkg::hsla_t hsla,
	output logic                done,
	output h2r_pkg::rgba_t      rgba
);

	logic           front_valid;
	logic [33:0]    y_c;
	logic [33:0]    y_x;
	logic [33:0]    y_m;
	h2r_pkg::side_t side_s4;
	h2r_pkg::side_t side_s5;
	h2r_pkg::side_t side_s6;
	h2r_pkg::side_t side_s7;

	logic           q_valid;
	logic           q_valid_x;
	logic           q_valid_m;
	logic [11:0]    q_c;
	logic [11:0]    q_x;
	logic [11:0]    q_m;

	logic           v_s8;
	h2r_pkg::rgba_t rgba_s8;
	h2r_pkg::rgba_t rgba_next;

	// The pipeline never stalls, so a transfer is taken on every start.
	assign busy = 1'b0;

	// Chroma front end.
	h2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.hsla      (hsla),
		.out_valid (front_valid),
		.y_c       (y_c),
		.y_x       (y_x),
		.y_m       (y_m),
		.side      (side_s4)
	);

	// One quantizer per channel term.
	h2r_q12_round u_round_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.y         (y_c),
		.out_valid (q_valid),
		.q         (q_c)
	);

	h2r_q12_round u_round_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.y         (y_x),
		.out_valid (q_valid_x),
		.q         (q_x)
	);

	h2r_q12_round u_round_m (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.y         (y_m),
		.out_valid (q_valid_m),
		.q         (q_m)
	);

	// Sector and alpha follow the quantizer stages.
	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
	end

	// Place C, X and the bare offset on red, green and blue by hue sector.
	always_comb begin
		rgba_next.alpha_out = side_s7.alpha;
		unique case (side_s7.sector)
			h2r_pkg::SEC_RED_YEL: begin
				rgba_next.red   = q_c;
				rgba_next.green = q_x;
				rgba_next.blue  = q_m;
			end
			h2r_pkg::SEC_YEL_GRN: begin
				rgba_next.red   = q_x;
				rgba_next.green = q_c;
				rgba_next.blue  = q_m;
			end
			h2r_pkg::SEC_GRN_CYN: begin
				rgba_next.red   = q_m;
				rgba_next.green = q_c;
				rgba_next.blue  = q_x;
			end
			h2r_pkg::SEC_CYN_BLU: begin
				rgba_next.red   = q_m;
				rgba_next.green = q_x;
				rgba_next.blue  = q_c;
			end
			h2r_pkg::SEC_BLU_MAG: begin
				rgba_next.red   = q_x;
				rgba_next.green = q_m;
				rgba_next.blue  = q_c;
			end
			default: begin
				rgba_next.red   = q_c;
				rgba_next.green = q_m;
				rgba_next.blue  = q_x;
			end
		endcase
	end

	// Output register and result strobe; all three quantizers run in lockstep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= q_valid & q_valid_x & q_valid_m;
		end
	end

	always_ff @(posedge clk) begin
		rgba_s8 <= rgba_next;
	end

	assign done = v_s8;
	assign rgba = rgba_s8;

	// Every result comes from a matching earlier transfer on start.
	`H2R_ASSERT_NOW(a_done_latency, done, $past(start, 8), "result without a matching transfer")

	// Alpha passes through with the pixel.
	`H2R_ASSERT_NOW(a_alpha_pass, done, rgba.alpha_out == $past(hsla.alpha_in, 8),
		"alpha does not match its input pixel")

	// A pixel with no saturation comes out gray.
	`H2R_ASSERT_NEXT(a_gray, $past(start && (hsla.saturation == 10'd0), 7),
		(rgba.red == rgba.green) && (rgba.green == rgba.blue),
		"zero saturation did not give equal channels")

endmodule

`default_nettype wire
